@@ rtl/core/tht_pkg.sv @@
package tht_pkg;

  // Defaults for the top-level parameters.
  localparam int NEIGHBORS_DEF   = 32;
  localparam int TIMER_WIDTH_DEF = 32;

  // Divisor applied to the random word when the firing time is drawn.
  localparam int RandTop = 65535;

  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 24;
  localparam int CMD_W       = 3;
  localparam int CFG_ADDR_W  = 4;
  localparam int CFG_DATA_W  = 32;

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK   = 3'd0,
    CMD_HELLO  = 3'd1,
    CMD_NEWNB  = 3'd2,
    CMD_START  = 3'd3,
    CMD_STOP   = 3'd4,
    CMD_RESET  = 3'd5
  } cmd_t;

  typedef enum logic [1:0] {
    REG_IMIN   = 2'd0,
    REG_IMAX   = 2'd1,
    REG_K      = 2'd2,
    REG_HDUR   = 2'd3
  } reg_idx_t;

  localparam logic [15:0] IMIN_RST = 16'd3840;
  localparam logic [3:0]  IMAX_RST = 4'd8;
  localparam logic [7:0]  K_RST    = 8'd2;
  localparam logic [15:0] HDUR_RST = 16'd640;

endpackage

@@ rtl/core/tht_draw.sv @@
module tht_draw
  import tht_pkg::*;
#(
  parameter int TW = TIMER_WIDTH_DEF
) (
  input  logic [TW-1:0] half_len,
  input  logic [15:0]   rnd,
  output logic [TW-1:0] t_drawn
);

  localparam int PW = TW + 16;
  localparam int RW = 21;

  logic [PW-1:0] prod;
  logic [PW-1:0] q_est;
  logic [PW-1:0] rem_full;
  logic [RW-1:0] rem;
  logic [RW-1:0] q_fix;
  logic [PW-1:0] quot;

  assign prod = PW'(half_len) * PW'(rnd);

  // Dividing by 2^16-1 is the series of right shifts by multiples of 16.
  // The truncated sum falls short by a few units, fixed up from the remainder.
  always_comb begin
    q_est = '0;
    for (int k = 1; 16 * k < PW; k++) begin
      q_est = q_est + (prod >> (16 * k));
    end
  end

  assign rem_full = prod - (q_est << 16) + q_est;
  assign rem      = rem_full[RW-1:0];
  assign q_fix    = (rem + (rem >> 16) + RW'(1)) >> 16;
  assign quot     = q_est + PW'(q_fix);

  // The quotient never exceeds half_len, so the sum stays within the timer width.
  assign t_drawn = half_len + quot[TW-1:0];

endmodule

@@ rtl/core/trickle_hello_timer_core.sv @@
// Trickle timer for HELLO broadcasts with a hello window after each firing time.
// Requests enter on the in_ channel: in_tuser carries the command (tick, authentic
// hello, new neighbor, start, stop, reset) and in_tdata its operands. Every request
// produces exactly one result on the out_ channel with the broadcast, challenge
// change and reset flags plus the doubling count, heard count and running status.
// An accepted request sits in the input register, then the whole update of the
// timer state and the result are computed combinationally and registered together
// into the state and the output register, from which the result is taken. One
// request per cycle is sustained while the receiver takes results. The longest
// path is the draw of the firing time (one 16-bit by timer-width multiply and a
// divide by 65535 done with shifts and adds).
// When the receiver stalls, the output register holds its result, the input
// register fills and in_tready drops until the result is taken.
// After reset both timers are stopped, all counters and the heard bitmap are
// zero and the registers hold their default values. The cfg_ port must be written
// only while no request is in flight; the block itself does not enforce this.
module trickle_hello_timer_core
  import tht_pkg::*;
#(
  parameter int NEIGHBORS   = NEIGHBORS_DEF,
  parameter int TIMER_WIDTH = TIMER_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // [4:0] neighbor_index, [12:5] permanent_count, [28:13] random_value
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // [2:0] cmd
  input  logic [CMD_W-1:0]       in_tuser,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // [0] broadcast_hello, [1] change_challenge, [2] trickle_was_reset,
  // [6:3] doublings, [22:7] heard_count, [23] running
  output logic [OUT_TDATA_W-1:0] out_tdata,
  input  logic                   cfg_psel,
  input  logic                   cfg_penable,
  input  logic                   cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0]  cfg_paddr,
  input  logic [CFG_DATA_W-1:0]  cfg_pwdata,
  output logic [CFG_DATA_W-1:0]  cfg_prdata,
  output logic                   cfg_pready
);

  localparam int TW = TIMER_WIDTH;
  localparam int NB = NEIGHBORS;

  // Configuration registers
  logic [15:0] imin_r;
  logic [3:0]  imax_r;
  logic [7:0]  k_r;
  logic [15:0] hdur_r;
  reg_idx_t    cfg_idx;
  logic        cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_idx    = reg_idx_t'(cfg_paddr[3:2]);
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      imin_r <= IMIN_RST;
      imax_r <= IMAX_RST;
      k_r    <= K_RST;
      hdur_r <= HDUR_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_IMIN: imin_r <= cfg_pwdata[15:0];
        REG_IMAX: imax_r <= cfg_pwdata[3:0];
        REG_K:    k_r    <= cfg_pwdata[7:0];
        REG_HDUR: hdur_r <= cfg_pwdata[15:0];
        default:  ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_IMIN: cfg_prdata = CFG_DATA_W'(imin_r);
      REG_IMAX: cfg_prdata = CFG_DATA_W'(imax_r);
      REG_K:    cfg_prdata = CFG_DATA_W'(k_r);
      REG_HDUR: cfg_prdata = CFG_DATA_W'(hdur_r);
      default:  cfg_prdata = '0;
    endcase
  end

  // Input register and output register
  logic        a_valid_r;
  cmd_t        a_cmd_r;
  logic [4:0]  a_idx_r;
  logic [7:0]  a_pc_r;
  logic [15:0] a_rnd_r;
  logic        exec;
  logic        out_valid_r;
  logic [OUT_TDATA_W-1:0] out_data_r;
  logic [OUT_TDATA_W-1:0] out_data_nxt;

  assign exec       = a_valid_r & (~out_valid_r | out_tready);
  assign in_tready  = ~a_valid_r | exec;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_tready) a_valid_r <= in_tvalid;
      if (exec) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      a_cmd_r <= cmd_t'(in_tuser);
      a_idx_r <= in_tdata[4:0];
      a_pc_r  <= in_tdata[12:5];
      a_rnd_r <= in_tdata[28:13];
    end
    if (exec) out_data_r <= out_data_nxt;
  end

  // Timer state
  logic [3:0]    dc_r, dc_nxt;
  logic [15:0]   hc_r, hc_nxt;
  logic [7:0]    nnc_r, nnc_nxt;
  logic [NB-1:0] heard_r, heard_nxt;
  logic [TW-1:0] rem_r, rem_nxt;
  logic          wait_r, wait_nxt;
  logic [TW-1:0] chosen_r, chosen_nxt;
  logic          armed_r, armed_nxt;
  logic [15:0]   hrem_r, hrem_nxt;
  logic          harmed_r, harmed_nxt;

  function automatic logic [TW-1:0] ilen_f(input logic [15:0] imin, input logic [3:0] dc);
    logic [30:0] full;
    logic        sat;
    full = {15'd0, imin} << dc;
    sat  = 1'b0;
    for (int b = 0; b < 31; b++) begin
      if (b >= TW && full[b]) sat = 1'b1;
    end
    ilen_f = sat ? '1 : TW'(full);
  endfunction

  // Decisions for the current request
  logic          is_tick;
  logic          trk_fire;
  logic          at_t_tick;
  logic          ivl_end;
  logic          hello_dec;
  logic          hello_end;
  logic [7:0]    thr;
  logic [7:0]    nnc_mid;
  logic [7:0]    nnc_inc;
  logic          tick_reset;
  logic          nn_reset;
  logic          do_reset;
  logic          do_at_t;
  logic [3:0]    dc_inc;
  logic [3:0]    draw_dc;
  logic [TW-1:0] draw_len;
  logic [TW-1:0] t_drawn;
  logic [TW-1:0] cur_len;
  logic [TW-1:0] rest;
  logic          bc;
  logic [NB-1:0] idx_hot;

  assign is_tick    = (a_cmd_r == CMD_TICK);
  assign trk_fire   = is_tick && armed_r && (rem_r == TW'(1));
  assign at_t_tick  = trk_fire && wait_r;
  assign ivl_end    = trk_fire && !wait_r;
  assign hello_dec  = is_tick && harmed_r && !at_t_tick;
  assign hello_end  = hello_dec && (hrem_r == 16'd1);
  assign thr        = (a_pc_r[7:2] > 6'd1) ? {2'b00, a_pc_r[7:2]} : 8'd1;
  assign nnc_mid    = ivl_end ? 8'd0 : nnc_r;
  assign tick_reset = hello_end && (nnc_mid >= thr);
  assign nnc_inc    = (nnc_r != 8'hFF) ? nnc_r + 8'd1 : nnc_r;
  assign nn_reset   = (a_cmd_r == CMD_NEWNB) && (nnc_inc == thr) && !harmed_r;
  assign do_reset   = tick_reset || nn_reset || (a_cmd_r == CMD_RESET);
  assign do_at_t    = at_t_tick || (a_cmd_r == CMD_START);
  assign dc_inc     = (dc_r < imax_r) ? dc_r + 4'd1 : dc_r;
  assign draw_dc    = do_reset ? 4'd0 : dc_inc;
  assign draw_len   = ilen_f(imin_r, draw_dc);
  assign cur_len    = ilen_f(imin_r, dc_r);

  tht_draw #(
    .TW (TW)
  ) u_draw (
    .half_len (draw_len >> 1),
    .rnd      (a_rnd_r),
    .t_drawn  (t_drawn)
  );

  // Remainder of the interval after the firing time, never shorter than the window.
  always_comb begin
    rest = (cur_len > chosen_r) ? cur_len - chosen_r : '0;
    if (rest < TW'(hdur_r)) rest = TW'(hdur_r);
  end

  always_comb begin
    for (int i = 0; i < NB; i++) begin
      idx_hot[i] = (7'(a_idx_r) == 7'(i));
    end
  end

  assign bc = do_at_t && (hc_r < 16'(k_r));

  always_comb begin
    dc_nxt     = dc_r;
    hc_nxt     = hc_r;
    nnc_nxt    = nnc_r;
    heard_nxt  = heard_r;
    rem_nxt    = rem_r;
    wait_nxt   = wait_r;
    chosen_nxt = chosen_r;
    armed_nxt  = armed_r;
    hrem_nxt   = hrem_r;
    harmed_nxt = harmed_r;

    unique case (a_cmd_r)
      CMD_TICK: begin
        if (armed_r) rem_nxt = rem_r - TW'(1);
        if (ivl_end) dc_nxt = dc_inc;
        if (hello_dec) hrem_nxt = hrem_r - 16'd1;
        if (hello_end) harmed_nxt = 1'b0;
      end
      CMD_HELLO: begin
        if ((heard_r & idx_hot) == '0 && idx_hot != '0) begin
          heard_nxt = heard_r | idx_hot;
          if (hc_r != 16'hFFFF) hc_nxt = hc_r + 16'd1;
        end
      end
      CMD_NEWNB: nnc_nxt = nnc_inc;
      CMD_STOP: begin
        armed_nxt  = 1'b0;
        rem_nxt    = '0;
        harmed_nxt = 1'b0;
        hrem_nxt   = '0;
      end
      default: ;
    endcase

    if (do_at_t) begin
      if (bc) heard_nxt = '0;
      rem_nxt    = (rest != '0) ? rest : TW'(1);
      wait_nxt   = 1'b0;
      armed_nxt  = 1'b1;
      hrem_nxt   = (hdur_r != 16'd0) ? hdur_r : 16'd1;
      harmed_nxt = 1'b1;
    end

    if (do_reset) begin
      harmed_nxt = 1'b0;
      hrem_nxt   = '0;
      dc_nxt     = '0;
    end

    // A new firing time is drawn at the end of an interval and on every reset.
    if (ivl_end || do_reset) begin
      chosen_nxt = t_drawn;
      rem_nxt    = (t_drawn != '0) ? t_drawn : TW'(1);
      wait_nxt   = 1'b1;
      armed_nxt  = 1'b1;
      hc_nxt     = '0;
      nnc_nxt    = '0;
    end
  end

  assign out_data_nxt = {armed_nxt, hc_nxt, dc_nxt, do_reset, hello_end, bc};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dc_r     <= '0;
      hc_r     <= '0;
      nnc_r    <= '0;
      heard_r  <= '0;
      rem_r    <= '0;
      wait_r   <= 1'b0;
      chosen_r <= '0;
      armed_r  <= 1'b0;
      hrem_r   <= '0;
      harmed_r <= 1'b0;
    end else if (exec) begin
      dc_r     <= dc_nxt;
      hc_r     <= hc_nxt;
      nnc_r    <= nnc_nxt;
      heard_r  <= heard_nxt;
      rem_r    <= rem_nxt;
      wait_r   <= wait_nxt;
      chosen_r <= chosen_nxt;
      armed_r  <= armed_nxt;
      hrem_r   <= hrem_nxt;
      harmed_r <= harmed_nxt;
    end
  end

  // An armed timer always has ticks left to count.
  a_trickle_rem: assert property (@(posedge clk) disable iff (!rst_n)
    armed_r |-> (rem_r != '0))
    else $error("trickle timer armed with zero remaining");

  a_hello_rem: assert property (@(posedge clk) disable iff (!rst_n)
    harmed_r |-> (hrem_r != '0))
    else $error("hello window armed with zero remaining");

  // A broadcast and a timer reset never come from the same request.
  a_bc_rst_excl: assert property (@(posedge clk) disable iff (!rst_n)
    exec |-> !(bc && do_reset))
    else $error("broadcast and reset on one request");

  // A reset always leaves the trickle timer running with no doublings.
  a_reset_runs: assert property (@(posedge clk) disable iff (!rst_n)
    (exec && do_reset) |=> (armed_r && wait_r && dc_r == '0))
    else $error("reset did not rearm the trickle timer");

endmodule

@@ bench/trickle_hello_timer_core_test.sv @@
`timescale 1ns / 100ps

module trickle_hello_timer_core_test;
  import tht_pkg::*;

  localparam int CYCLE_LIMIT = 300000;
  localparam int PRINT_LIMIT = 200;

  typedef struct packed {
    logic        broadcast;
    logic        challenge;
    logic        restarted;
    logic [3:0]  doublings;
    logic [15:0] heard;
    logic        running;
  } timer_status_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  // [4:0] neighbor_index, [12:5] permanent_count, [28:13] random_value
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  // [2:0] cmd
  logic [CMD_W-1:0]       in_tuser = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  // [0] broadcast_hello, [1] change_challenge, [2] trickle_was_reset,
  // [6:3] doublings, [22:7] heard_count, [23] running
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_psel = 1'b0;
  logic                   cfg_penable = 1'b0;
  logic                   cfg_pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0]  cfg_paddr = '0;
  logic [CFG_DATA_W-1:0]  cfg_pwdata = '0;
  logic [CFG_DATA_W-1:0]  cfg_prdata;
  logic                   cfg_pready;

  // Register copies used by the predictor.
  logic [15:0] imin_setting = IMIN_RST;
  logic [3:0]  imax_setting = IMAX_RST;
  logic [7:0]  k_setting = K_RST;
  logic [15:0] window_setting = HDUR_RST;

  // Predicted timer state.
  logic [3:0]  doublings_now = '0;
  logic [15:0] heard_now = '0;
  logic [7:0]  newcomers = '0;
  logic [31:0] heard_mask = '0;
  logic [31:0] trickle_left = '0;
  logic        before_fire = 1'b0;
  logic [31:0] fire_time = '0;
  logic        trickle_on = 1'b0;
  logic [15:0] window_left = '0;
  logic        window_on = 1'b0;

  timer_status_t status_expected[$];
  timer_status_t status_head;
  int mismatches = 0;
  int cycle_count = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  trickle_hello_timer_core uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    mismatches++;
    if (mismatches <= PRINT_LIMIT)
      $display("%0t ns: %s: got %0h, expected %0h", $time, what, got, want);
  endtask

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  function automatic logic [63:0] interval_ticks();
    logic [63:0] v;
    v = 64'(imin_setting) << doublings_now;
    return (v > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : v;
  endfunction

  function automatic void draw_fire_time(logic [15:0] rnd);
    logic [63:0] half;
    logic [63:0] t;
    half = interval_ticks() >> 1;
    t = half + (half * rnd) / 64'(RandTop);
    fire_time = t[31:0];
    trickle_left = (t == 0) ? 32'd1 : t[31:0];
    before_fire = 1'b1;
    trickle_on = 1'b1;
    heard_now = '0;
    newcomers = '0;
  endfunction

  function automatic void restart_timer(logic [15:0] rnd);
    window_on = 1'b0;
    window_left = '0;
    doublings_now = '0;
    draw_fire_time(rnd);
  endfunction

  // The firing time: maybe broadcast, then arm the interval end and the window.
  function automatic logic fire_at_t();
    logic        bc;
    logic [63:0] rest;
    bc = 1'b0;
    if (heard_now < k_setting) begin
      bc = 1'b1;
      heard_mask = '0;
    end
    // A lowered imin can leave the interval shorter than the firing time.
    rest = (interval_ticks() > fire_time) ? interval_ticks() - fire_time : 64'd0;
    if (rest < 64'(window_setting)) rest = 64'(window_setting);
    trickle_left = (rest == 0) ? 32'd1 : rest[31:0];
    before_fire = 1'b0;
    trickle_on = 1'b1;
    window_left = (window_setting == 0) ? 16'd1 : window_setting;
    window_on = 1'b1;
    return bc;
  endfunction

  function automatic timer_status_t advance_timer(cmd_t op, logic [4:0] nb,
                                                  logic [7:0] perm, logic [15:0] rnd);
    timer_status_t s;
    logic          fired_now;
    logic [7:0]    need;
    s = '0;
    fired_now = 1'b0;
    need = (perm[7:2] > 6'd1) ? {2'b00, perm[7:2]} : 8'd1;
    case (op)
      CMD_TICK: begin
        if (trickle_on) begin
          trickle_left = trickle_left - 32'd1;
          if (trickle_left == 0) begin
            if (before_fire) begin
              s.broadcast = fire_at_t();
              fired_now = 1'b1;
            end else begin
              if (doublings_now < imax_setting) doublings_now = doublings_now + 4'd1;
              draw_fire_time(rnd);
            end
          end
        end
        // A window started by this same tick is not counted down yet.
        if (window_on && !fired_now) begin
          window_left = window_left - 16'd1;
          if (window_left == 0) begin
            window_on = 1'b0;
            s.challenge = 1'b1;
            if (newcomers >= need) begin
              restart_timer(rnd);
              s.restarted = 1'b1;
            end
          end
        end
      end
      CMD_HELLO: begin
        // Every 5-bit index names one of the 32 table entries.
        if (!heard_mask[nb]) begin
          heard_mask[nb] = 1'b1;
          if (heard_now != 16'hFFFF) heard_now = heard_now + 16'd1;
        end
      end
      CMD_NEWNB: begin
        if (newcomers != 8'hFF) newcomers = newcomers + 8'd1;
        if (newcomers == need && !window_on) begin
          restart_timer(rnd);
          s.restarted = 1'b1;
        end
      end
      CMD_START: s.broadcast = fire_at_t();
      CMD_STOP: begin
        trickle_on = 1'b0;
        trickle_left = '0;
        window_on = 1'b0;
        window_left = '0;
      end
      CMD_RESET: begin
        restart_timer(rnd);
        s.restarted = 1'b1;
      end
      default: ;
    endcase
    s.doublings = doublings_now;
    s.heard = heard_now;
    s.running = trickle_on;
    return s;
  endfunction

  // ---------------------------------------------------------------------------
  // Result side
  // ---------------------------------------------------------------------------
  always @(posedge clk) out_tready <= ($urandom_range(99) >= recv_idle_pct);

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (status_expected.size() == 0) begin
        report_mismatch("result without a pending request", 32'(out_tdata), 32'd0);
      end else begin
        status_head = status_expected.pop_front();
        if (out_tdata[0] !== status_head.broadcast)
          report_mismatch("broadcast_hello", 32'(out_tdata[0]),
                          32'(status_head.broadcast));
        if (out_tdata[1] !== status_head.challenge)
          report_mismatch("change_challenge", 32'(out_tdata[1]),
                          32'(status_head.challenge));
        if (out_tdata[2] !== status_head.restarted)
          report_mismatch("trickle_was_reset", 32'(out_tdata[2]),
                          32'(status_head.restarted));
        if (out_tdata[6:3] !== status_head.doublings)
          report_mismatch("doublings", 32'(out_tdata[6:3]), 32'(status_head.doublings));
        if (out_tdata[22:7] !== status_head.heard)
          report_mismatch("heard_count", 32'(out_tdata[22:7]), 32'(status_head.heard));
        if (out_tdata[23] !== status_head.running)
          report_mismatch("running", 32'(out_tdata[23]), 32'(status_head.running));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Request side and configuration
  // ---------------------------------------------------------------------------
  task automatic send_request(cmd_t op, logic [4:0] nb, logic [7:0] perm, logic [15:0] rnd);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {3'b000, rnd, perm, nb};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    status_expected.push_back(advance_timer(op, nb, perm, rnd));
  endtask

  task automatic wait_for_results();
    in_tvalid <= 1'b0;
    while (status_expected.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic check_register(reg_idx_t r, logic [31:0] want);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= {r, 2'b00};
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    if (cfg_prdata !== want) report_mismatch("register readback", cfg_prdata, want);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_register(reg_idx_t r, logic [31:0] v);
    logic [31:0] want;
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {r, 2'b00};
    cfg_pwdata  <= v;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    case (r)
      REG_IMIN: begin imin_setting = v[15:0];  want = {16'd0, v[15:0]}; end
      REG_IMAX: begin imax_setting = v[3:0];   want = {28'd0, v[3:0]}; end
      REG_K:    begin k_setting = v[7:0];      want = {24'd0, v[7:0]}; end
      default:  begin window_setting = v[15:0]; want = {16'd0, v[15:0]}; end
    endcase
    check_register(r, want);
  endtask

  task automatic set_timer_config(logic [31:0] imin, logic [31:0] imax,
                                  logic [31:0] k, logic [31:0] hdur);
    wait_for_results();
    write_register(REG_IMIN, imin);
    write_register(REG_IMAX, imax);
    write_register(REG_K, k);
    write_register(REG_HDUR, hdur);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic test_register_defaults();
    check_register(REG_IMIN, 32'(IMIN_RST));
    check_register(REG_IMAX, 32'(IMAX_RST));
    check_register(REG_K, 32'(K_RST));
    check_register(REG_HDUR, 32'(HDUR_RST));
  endtask

  task automatic test_directed_commands();
    set_timer_config(4, 2, 2, 2);
    send_request(CMD_TICK, 0, 0, 16'($urandom_range(65535)));
    send_request(CMD_HELLO, 0, 0, 0);
    send_request(CMD_HELLO, 31, 255, 16'hFFFF);
    // A second hello from the same neighbor is not counted.
    send_request(CMD_HELLO, 0, 0, 0);
    // Start right after reset fires at time zero.
    send_request(CMD_START, 0, 0, 0);
    send_request(CMD_NEWNB, 0, 255, 0);
    send_request(CMD_TICK, 0, 0, 0);
    // The window ends with the newcomer count at the threshold.
    send_request(CMD_TICK, 0, 4, 16'hFFFF);
    repeat (5) send_request(CMD_TICK, 0, 0, 16'($urandom_range(65535)));
    send_request(CMD_HELLO, 5, 0, 0);
    send_request(CMD_STOP, 0, 0, 0);
    send_request(CMD_TICK, 0, 0, 0);
    // Hellos still count while the timer is stopped.
    send_request(CMD_HELLO, 9, 0, 0);
    send_request(CMD_RESET, 0, 0, 0);
    // Threshold reached with no window running restarts the timer.
    send_request(CMD_NEWNB, 0, 3, 16'hFFFF);
    repeat (6) send_request(CMD_TICK, 0, 0, 16'($urandom_range(65535)));
  endtask

  task automatic test_shrunk_interval();
    set_timer_config(65535, 0, 255, 3);
    send_request(CMD_RESET, 0, 0, 16'hFFFF);
    wait_for_results();
    // The interval is now shorter than the chosen firing time.
    write_register(REG_IMIN, 2);
    send_request(CMD_START, 0, 0, 0);
    repeat (6) send_request(CMD_TICK, 0, 0, 16'($urandom_range(65535)));
  endtask

  task automatic test_doubling_limit();
    set_timer_config(2, 3, 255, 1);
    send_request(CMD_RESET, 0, 0, 0);
    repeat (60) send_request(CMD_TICK, 0, 0, 16'($urandom_range(65535)));
    // Lowering the cap does not bring the doubling count back down.
    set_timer_config(2, 1, 255, 1);
    repeat (20) send_request(CMD_TICK, 0, 0, 16'($urandom_range(65535)));
    set_timer_config(65535, 15, 255, 65535);
    send_request(CMD_START, 0, 0, 0);
    send_request(CMD_HELLO, 17, 0, 0);
    send_request(CMD_HELLO, 30, 0, 0);
    repeat (3) send_request(CMD_TICK, 0, 0, 16'hFFFF);
    send_request(CMD_RESET, 0, 0, 16'hFFFF);
    repeat (2) send_request(CMD_TICK, 0, 0, 16'hFFFF);
    send_request(CMD_START, 0, 0, 0);
  endtask

  task automatic test_random_traffic(int count);
    int          pick;
    cmd_t        op;
    logic [15:0] rnd;
    logic [7:0]  perm;
    for (int n = 0; n < count; n++) begin
      if (n == count / 2) wait_for_results();
      pick = $urandom_range(99);
      if (pick < 55) op = CMD_TICK;
      else if (pick < 70) op = CMD_HELLO;
      else if (pick < 80) op = CMD_NEWNB;
      else if (pick < 87) op = CMD_START;
      else if (pick < 92) op = CMD_STOP;
      else op = CMD_RESET;
      case ($urandom_range(7))
        0: rnd = 16'h0000;
        1: rnd = 16'hFFFF;
        default: rnd = 16'($urandom_range(65535));
      endcase
      // Mostly small neighbor counts so that the threshold is often reached.
      perm = ($urandom_range(3) != 0) ? 8'($urandom_range(15)) : 8'($urandom_range(255));
      send_request(op, 5'($urandom_range(31)), perm, rnd);
    end
    wait_for_results();
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send_idle_pct = 6;
    recv_idle_pct = 81;
    test_register_defaults();
    test_directed_commands();
    test_shrunk_interval();
    test_doubling_limit();
    set_timer_config(2, 0, 0, 1);
    test_random_traffic(92);
    send_idle_pct = 81;
    recv_idle_pct = 6;
    set_timer_config(5, 4, 3, 4);
    test_random_traffic(92);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_timer_config(3, 6, 1, 2);
    test_random_traffic(92);
    repeat (10) @(posedge clk);
    if (mismatches == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
